// ===== design/ospw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ospw_pkg;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 17;
    localparam int HEAD_W    = 16;
    localparam int STREAK_W  = 8;
    localparam int INDEX_W   = 4;
    localparam int RADIUS_W  = 16;
    localparam int STEP_W    = 10;
    localparam int GOAL_W    = 18;
    localparam int DIFF_W    = 19;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_STEP  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_RADIUS = 2'd3;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_NEXT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESUME  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOST    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTORE = 2'd3;

    // reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RESET       = 16'd500;
    localparam logic [STEP_W-1:0]   RADIUS_STEP_RESET  = 10'd350;
    localparam logic [RADIUS_W-1:0] START_RADIUS_RESET = 16'd1250;
    localparam logic [INDEX_W-1:0]  INDEX_RESET        = 4'd1;
    localparam logic [INDEX_W-1:0]  INDEX_LAST         = 4'd9;
    localparam logic [3:0]          ROT_MAX            = 4'd15;
    localparam logic [3:0]          ROT_GROW_MIN       = 4'd6;
    localparam logic [STREAK_W-1:0] STREAK_SKIP        = 8'd4;

    // floor(r / 1000) as (r * K) >> SH, exact for 16-bit r
    localparam int DIV_K_W = 17;
    localparam int PROD_W  = RADIUS_W + DIV_K_W;
    localparam logic [DIV_K_W-1:0] DIV1000_K = 17'd67109;
    localparam int DIV1000_SH = 26;
    localparam int METRE_W = PROD_W - DIV1000_SH;

    // CORDIC
    localparam int CORDIC_STEPS   = 16;
    localparam int CORDIC_ITER_W  = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W     = 5;
    localparam int CORDIC_W       = DIFF_W + 2;

    // offset codes: full radius or half radius, either sign
    localparam logic [1:0] OFF_RP = 2'd0;
    localparam logic [1:0] OFF_HP = 2'd1;
    localparam logic [1:0] OFF_HN = 2'd2;
    localparam logic [1:0] OFF_RN = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic signed [POS_W-1:0]    cur_x;
        logic signed [POS_W-1:0]    cur_y;
        logic [HEAD_W-1:0]          cur_heading;
        logic                       blocked;
        logic [STREAK_W-1:0]        obstacle_streak;
        logic [INDEX_W-1:0]         random_start;
    } req_t;

    typedef struct packed {
        logic [RADIUS_W-1:0]        radius_now;
        logic [INDEX_W-1:0]         search_position;
        logic signed [HEAD_W-1:0]   goal_heading;
        logic signed [GOAL_W-1:0]   goal_y;
        logic signed [GOAL_W-1:0]   goal_x;
    } res_t;

    typedef struct packed {
        logic [1:0] x_sel;
        logic [1:0] y_sel;
    } offset_t;

    function automatic logic [HEAD_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
        logic [HEAD_W-1:0] v;
        case (idx)
            5'd0:    v = 16'd8192;
            5'd1:    v = 16'd4836;
            5'd2:    v = 16'd2555;
            5'd3:    v = 16'd1297;
            5'd4:    v = 16'd651;
            5'd5:    v = 16'd326;
            5'd6:    v = 16'd163;
            5'd7:    v = 16'd81;
            5'd8:    v = 16'd41;
            5'd9:    v = 16'd20;
            5'd10:   v = 16'd10;
            5'd11:   v = 16'd5;
            5'd12:   v = 16'd3;
            5'd13:   v = 16'd1;
            5'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // odd whole-metre radius above 2, from the registered reciprocal product
    function automatic logic odd_above_two(input logic [PROD_W-1:0] prod);
        logic [METRE_W-1:0] d;
        d = prod[PROD_W-1:DIV1000_SH];
        return d[0] && (d > METRE_W'(2));
    endfunction

    // heading sector, upper bounds inclusive: count of floor(k*65536/12) exceeded
    function automatic logic [INDEX_W-1:0] sector_index(input logic cw,
                                                        input logic [HEAD_W-1:0] hd);
        logic [3:0] s;
        logic [INDEX_W-1:0] v;
        s = 4'd0;
        if (hd > 16'd5461)  s = s + 4'd1;
        if (hd > 16'd10922) s = s + 4'd1;
        if (hd > 16'd16384) s = s + 4'd1;
        if (hd > 16'd21845) s = s + 4'd1;
        if (hd > 16'd27306) s = s + 4'd1;
        if (hd > 16'd32768) s = s + 4'd1;
        if (hd > 16'd38229) s = s + 4'd1;
        if (hd > 16'd43690) s = s + 4'd1;
        if (hd > 16'd49152) s = s + 4'd1;
        if (hd > 16'd54613) s = s + 4'd1;
        if (hd > 16'd60074) s = s + 4'd1;
        if (cw)
        begin
            case (s)
                4'd0, 4'd1:        v = 4'd8;
                4'd2:              v = 4'd7;
                4'd3:              v = 4'd6;
                4'd4, 4'd5, 4'd6:  v = 4'd5;
                4'd7:              v = 4'd4;
                4'd8:              v = 4'd3;
                4'd9, 4'd10:       v = 4'd2;
                default:           v = 4'd1;
            endcase
        end
        else
        begin
            case (s)
                4'd0, 4'd1:        v = 4'd1;
                4'd2:              v = 4'd2;
                4'd3:              v = 4'd3;
                4'd4, 4'd5, 4'd6:  v = 4'd4;
                4'd7:              v = 4'd5;
                4'd8, 4'd9:        v = 4'd6;
                4'd10:             v = 4'd7;
                default:           v = 4'd8;
            endcase
        end
        return v;
    endfunction

    function automatic offset_t offset_sel(input logic cw, input logic [INDEX_W-1:0] p);
        offset_t o;
        if (cw)
        begin
            case (p)
                4'd1:    o = '{x_sel: OFF_RP, y_sel: OFF_HN};
                4'd2:    o = '{x_sel: OFF_HP, y_sel: OFF_RN};
                4'd3:    o = '{x_sel: OFF_HN, y_sel: OFF_RN};
                4'd4:    o = '{x_sel: OFF_RN, y_sel: OFF_HN};
                4'd5:    o = '{x_sel: OFF_RN, y_sel: OFF_HP};
                4'd6:    o = '{x_sel: OFF_HN, y_sel: OFF_RP};
                4'd7:    o = '{x_sel: OFF_HP, y_sel: OFF_RP};
                default: o = '{x_sel: OFF_RP, y_sel: OFF_HP};
            endcase
        end
        else
        begin
            case (p)
                4'd2:    o = '{x_sel: OFF_HP, y_sel: OFF_RP};
                4'd3:    o = '{x_sel: OFF_HN, y_sel: OFF_RP};
                4'd4:    o = '{x_sel: OFF_RN, y_sel: OFF_HP};
                4'd5:    o = '{x_sel: OFF_RN, y_sel: OFF_HN};
                4'd6:    o = '{x_sel: OFF_HN, y_sel: OFF_RN};
                4'd7:    o = '{x_sel: OFF_HP, y_sel: OFF_RN};
                4'd8:    o = '{x_sel: OFF_RP, y_sel: OFF_HN};
                default: o = '{x_sel: OFF_RP, y_sel: OFF_HP};
            endcase
        end
        return o;
    endfunction

    function automatic logic signed [GOAL_W-1:0] offset_val(input logic [1:0] sel,
                                                           input logic [RADIUS_W-1:0] r);
        logic signed [GOAL_W-1:0] full;
        logic signed [GOAL_W-1:0] half;
        logic signed [GOAL_W-1:0] v;
        full = GOAL_W'(r);
        half = GOAL_W'(r >> 1);
        case (sel)
            OFF_RP:  v = full;
            OFF_HP:  v = half;
            OFF_HN:  v = -half;
            default: v = -full;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/ospw_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ospw_cordic
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [ospw_pkg::DIFF_W-1:0]     dx,
    input  wire logic signed [ospw_pkg::DIFF_W-1:0]     dy,
    output      logic                                   done,
    output      logic signed [ospw_pkg::HEAD_W-1:0]     heading
);
    import ospw_pkg::*;

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [CORDIC_ITER_W-1:0]           iter_reg, iter_next;
    logic signed [CORDIC_W-1:0]         x_reg, x_next;
    logic signed [CORDIC_W-1:0]         y_reg, y_next;
    logic [HEAD_W-1:0]                  z_reg, z_next;
    logic                               zero_reg, zero_next;

    logic signed [CORDIC_W-1:0]         dx_w, dy_w, xs, ys;
    logic [HEAD_W-1:0]                  ang;
    logic                               last;

    assign dx_w = CORDIC_W'(dx);
    assign dy_w = CORDIC_W'(dy);
    assign xs   = x_reg >>> iter_reg;
    assign ys   = y_reg >>> iter_reg;
    assign ang  = atan_val(ATAN_IDX_W'(iter_reg));
    assign last = (iter_reg == CORDIC_ITER_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            zero_next = (dx == '0) && (dy == '0);
            // left half plane: rotate by pi first (+pi and -pi agree mod 2^16)
            if (dx < 0)
            begin
                x_next = -dx_w;
                y_next = -dy_w;
                z_next = 16'h8000;
            end
            else
            begin
                x_next = dx_w;
                y_next = dy_w;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[CORDIC_W-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            iter_next = iter_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    assign done    = done_reg;
    assign heading = zero_reg ? '0 : z_reg;

endmodule

`default_nettype wire

// ===== design/ospw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ospw_ctrl
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   req_valid,
    output      logic                                   req_ready,
    input  wire ospw_pkg::req_t                         req,
    input  wire logic                                   cfg_we,
    input  wire logic [ospw_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [ospw_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    output      logic                                   res_valid,
    input  wire logic                                   res_ready,
    output      ospw_pkg::res_t                         res,
    output      logic                                   cordic_start,
    output      logic signed [ospw_pkg::DIFF_W-1:0]     cordic_dx,
    output      logic signed [ospw_pkg::DIFF_W-1:0]     cordic_dy,
    input  wire logic                                   cordic_done,
    input  wire logic signed [ospw_pkg::HEAD_W-1:0]     cordic_heading
);
    import ospw_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SKIP   = 4'd1;
    localparam logic [3:0] ST_IDX    = 4'd2;
    localparam logic [3:0] ST_GROW   = 4'd3;
    localparam logic [3:0] ST_GROW2  = 4'd4;
    localparam logic [3:0] ST_GOAL   = 4'd5;
    localparam logic [3:0] ST_DIFF   = 4'd6;
    localparam logic [3:0] ST_CSTART = 4'd7;
    localparam logic [3:0] ST_CWAIT  = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    logic [3:0]                 state_reg, state_next;
    logic [INDEX_W-1:0]         pi_reg, pi_next;
    logic [RADIUS_W-1:0]        radius_reg, radius_next;
    logic [3:0]                 rot_reg, rot_next;
    logic                       cw_reg, cw_next;
    logic                       wp_reg, wp_next;

    logic signed [POS_W-1:0]    center_x_reg, center_y_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [RADIUS_W-1:0]        start_radius_reg;

    logic                       blk_reg, blk_next;
    logic                       skip_reg, skip_next;
    logic signed [POS_W-1:0]    cx_reg, cx_next;
    logic signed [POS_W-1:0]    cy_reg, cy_next;
    logic [INDEX_W-1:0]         p_reg, p_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic signed [GOAL_W-1:0]   gx_reg, gx_next;
    logic signed [GOAL_W-1:0]   gy_reg, gy_next;
    logic signed [DIFF_W-1:0]   dx_reg, dx_next;
    logic signed [DIFF_W-1:0]   dy_reg, dy_next;

    logic                       cw_new;
    logic [INDEX_W-1:0]         p_clamp;
    logic [RADIUS_W:0]          grown;
    offset_t                    off;

    assign req_ready = (state_reg == ST_IDLE);
    assign cw_new    = odd_above_two(prod_reg);
    assign p_clamp   = (pi_reg > INDEX_LAST) ? '0 : pi_reg;
    assign grown     = {1'b0, radius_reg} + (RADIUS_W + 1)'(step_reg);
    assign off       = offset_sel(cw_reg, p_reg);

    always_comb
    begin
        state_next  = state_reg;
        pi_next     = pi_reg;
        radius_next = radius_reg;
        rot_next    = rot_reg;
        cw_next     = cw_reg;
        wp_next     = wp_reg;
        blk_next    = blk_reg;
        skip_next   = skip_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        p_next      = p_reg;
        prod_next   = prod_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    blk_next  = req.blocked;
                    skip_next = req.blocked && (req.obstacle_streak >= STREAK_SKIP);
                    cx_next   = req.cur_x;
                    cy_next   = req.cur_y;
                    if (req.func == FUNC_LOST || req.func == FUNC_RESTORE)
                    begin
                        cw_next  = 1'b0;
                        rot_next = '0;
                        wp_next  = 1'b0;
                        gx_next  = '0;
                        gy_next  = '0;
                        if (req.func == FUNC_LOST)
                        begin
                            pi_next     = req.random_start;
                            radius_next = RADIUS_RESET;
                        end
                        else
                        begin
                            radius_next = start_radius_reg;
                        end
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        wp_next = 1'b1;
                        if (req.func == FUNC_RESUME)
                        begin
                            pi_next = sector_index(cw_reg, req.cur_heading);
                        end
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP:
            begin
                if (skip_reg)
                begin
                    pi_next = pi_reg + 1'b1;
                end
                prod_next  = radius_reg * DIV1000_K;
                state_next = ST_IDX;
            end
            ST_IDX:
            begin
                cw_next = cw_new;
                p_next  = p_clamp;
                pi_next = p_clamp;
                if (p_clamp == '0)
                begin
                    if (!blk_reg && rot_reg > ROT_GROW_MIN)
                    begin
                        radius_next = grown[RADIUS_W] ? '1 : grown[RADIUS_W-1:0];
                    end
                    state_next = ST_GROW;
                end
                else
                begin
                    if (!blk_reg)
                    begin
                        if (cw_new)
                        begin
                            pi_next = (p_clamp >= (INDEX_LAST - 1'b1)) ? '0 : p_clamp + 1'b1;
                        end
                        else
                        begin
                            pi_next = (p_clamp == INDEX_LAST) ? '0 : p_clamp + 1'b1;
                        end
                    end
                    state_next = ST_GOAL;
                end
            end
            ST_GROW:
            begin
                prod_next  = radius_reg * DIV1000_K;
                state_next = ST_GROW2;
            end
            ST_GROW2:
            begin
                pi_next    = odd_above_two(prod_reg) ? 4'd1 : 4'd2;
                rot_next   = '0;
                state_next = ST_GOAL;
            end
            ST_GOAL:
            begin
                gx_next = GOAL_W'(center_x_reg) + offset_val(off.x_sel, radius_reg);
                gy_next = GOAL_W'(center_y_reg) + offset_val(off.y_sel, radius_reg);
                if (rot_reg < ROT_MAX)
                begin
                    rot_next = rot_reg + 1'b1;
                end
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dx_next    = DIFF_W'(gx_reg) - DIFF_W'(cx_reg);
                dy_next    = DIFF_W'(gy_reg) - DIFF_W'(cy_reg);
                state_next = ST_CSTART;
            end
            ST_CSTART:
            begin
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (cordic_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pi_reg           <= INDEX_RESET;
            radius_reg       <= RADIUS_RESET;
            rot_reg          <= '0;
            cw_reg           <= 1'b0;
            wp_reg           <= 1'b0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            step_reg         <= RADIUS_STEP_RESET;
            start_radius_reg <= START_RADIUS_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            pi_reg     <= pi_next;
            radius_reg <= radius_next;
            rot_reg    <= rot_next;
            cw_reg     <= cw_next;
            wp_reg     <= wp_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_CENTER_X:     center_x_reg     <= cfg_wdata;
                    CFG_CENTER_Y:     center_y_reg     <= cfg_wdata;
                    CFG_RADIUS_STEP:  step_reg         <= cfg_wdata[STEP_W-1:0];
                    CFG_START_RADIUS: start_radius_reg <= cfg_wdata[RADIUS_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        skip_reg <= skip_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
    end

    assign cordic_start = (state_reg == ST_CSTART);
    assign cordic_dx    = dx_reg;
    assign cordic_dy    = dy_reg;

    assign res_valid           = (state_reg == ST_OUT);
    assign res.goal_x          = gx_reg;
    assign res.goal_y          = gy_reg;
    assign res.goal_heading    = wp_reg ? cordic_heading : '0;
    assign res.search_position = (pi_reg == '0) ? INDEX_LAST : pi_reg - 1'b1;
    assign res.radius_now      = radius_reg;

endmodule

`default_nettype wire

// ===== design/octagon_spiral_waypoint_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Signals                          Content
// s_        in   s_tvalid s_tready s_tdata s_tuser  waypoint request, tuser = func
// m_        out  m_tvalid m_tready m_tdata          goal and search state
// cfg_      in   cfg_we cfg_addr cfg_wdata          center, radius step, start radius
//
// A next or resume request runs through the skip, index, goal, difference and CORDIC
// states before its result, and point 0 adds the two grow states; the 16-step CORDIC
// atan2 unit dominates. Lost and restore requests go straight to the output state.
// One request is in flight at a time; s_tready is high only while the sequencer idles.
// The result sits in an output register, so a stalled m_tready blocks accept only once it is full.
// rst_n is asynchronous: state returns to point 1, radius 500 mm, registers to defaults.

module octagon_spiral_waypoint_sequencer
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output      logic                                   s_tready,
    // cur_x[16:0] cur_y[33:17] cur_heading[49:34] blocked[50]
    // obstacle_streak[58:51] random_start[62:59], bit 63 zero
    input  wire logic [63:0]                            s_tdata,
    // func[1:0]
    input  wire logic [ospw_pkg::FUNC_W-1:0]            s_tuser,
    output      logic                                   m_tvalid,
    input  wire logic                                   m_tready,
    // goal_x[17:0] goal_y[35:18] goal_heading[51:36] search_position[55:52]
    // radius_now[71:56]
    output      logic [71:0]                            m_tdata,
    input  wire logic                                   cfg_we,
    input  wire logic [ospw_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [ospw_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import ospw_pkg::*;

    req_t                       req;
    res_t                       res;
    res_t                       out_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       res_valid, res_ready;
    logic                       cordic_start, cordic_done;
    logic signed [DIFF_W-1:0]   cordic_dx, cordic_dy;
    logic signed [HEAD_W-1:0]   cordic_heading;

    assign req.func            = s_tuser;
    assign req.cur_x           = s_tdata[16:0];
    assign req.cur_y           = s_tdata[33:17];
    assign req.cur_heading     = s_tdata[49:34];
    assign req.blocked         = s_tdata[50];
    assign req.obstacle_streak = s_tdata[58:51];
    assign req.random_start    = s_tdata[62:59];

    ospw_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (s_tvalid),
        .req_ready      (s_tready),
        .req            (req),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .cordic_start   (cordic_start),
        .cordic_dx      (cordic_dx),
        .cordic_dy      (cordic_dy),
        .cordic_done    (cordic_done),
        .cordic_heading (cordic_heading)
    );

    ospw_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .dx      (cordic_dx),
        .dy      (cordic_dy),
        .done    (cordic_done),
        .heading (cordic_heading)
    );

    // output register: loads when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.radius_now, out_reg.search_position, out_reg.goal_heading,
                       out_reg.goal_y, out_reg.goal_x};

endmodule

`default_nettype wire

// ===== bench/tb_octagon_spiral_waypoint_sequencer.sv =====
`timescale 1ns / 1ps

module tb_octagon_spiral_waypoint_sequencer;

    import ospw_pkg::*;

    // heading units: 65536 per turn
    localparam int ATAN_STEP [0:15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                        41, 20, 10, 5, 3, 1, 1, 0};
    localparam int SECTOR_CCW [0:11] = '{1, 1, 2, 3, 4, 4, 4, 5, 6, 6, 7, 8};
    localparam int SECTOR_CW  [0:11] = '{8, 8, 7, 6, 5, 5, 5, 4, 3, 2, 2, 1};
    // offset multiples: 2 = r, 1 = r/2
    localparam int CCW_DX [0:9] = '{2, 2, 1, -1, -2, -2, -1, 1, 2, 2};
    localparam int CCW_DY [0:9] = '{1, 1, 2, 2, 1, -1, -2, -2, -1, 1};
    localparam int CW_DX  [0:9] = '{2, 2, 1, -1, -2, -2, -1, 1, 2, 2};
    localparam int CW_DY  [0:9] = '{1, -1, -2, -2, -1, 1, 2, 2, 1, 1};

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;
    logic [FUNC_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [71:0]            m_tdata;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    bit no_idle;
    int req_count [4];

    class waypoint_scoreboard;
        logic signed [POS_W-1:0] ctr_x;
        logic signed [POS_W-1:0] ctr_y;
        logic [STEP_W-1:0]       grow_step;
        logic [RADIUS_W-1:0]     home_radius;
        logic [INDEX_W-1:0]      pt_idx;
        logic [RADIUS_W-1:0]     radius;
        logic [3:0]              loops;
        bit                      cw;
        res_t                    goal_q [$];
        int mismatches;
        int checked;
        int n_cw;
        int n_grow;
        int n_sat;
        int n_zero;

        function new();
            ctr_x = '0;
            ctr_y = '0;
            grow_step = RADIUS_STEP_RESET;
            home_radius = START_RADIUS_RESET;
            pt_idx = INDEX_RESET;
            radius = RADIUS_RESET;
            loops = '0;
            cw = 1'b0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] v);
            case (addr)
                CFG_CENTER_X:    ctr_x = v;
                CFG_CENTER_Y:    ctr_y = v;
                CFG_RADIUS_STEP: grow_step = v[STEP_W-1:0];
                default:         home_radius = v[RADIUS_W-1:0];
            endcase
        endfunction

        function bit odd_metres(logic [RADIUS_W-1:0] r);
            int unsigned d;
            d = r / 1000;
            return (d % 2 == 1) && (d > 2);
        endfunction

        function logic [HEAD_W-1:0] heading_to(longint dy, longint dx);
            longint x;
            longint y;
            longint z;
            longint nx;
            longint ny;
            longint a;
            int i;
            if (dx == 0 && dy == 0)
                return '0;
            x = dx;
            y = dy;
            z = 0;
            if (x < 0)
            begin
                z = (y >= 0) ? 32768 : -32768;
                x = -x;
                y = -y;
            end
            for (i = 0; i < CORDIC_STEPS; i++)
            begin
                a = (i < 16) ? ATAN_STEP[i] : 0;
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z = z + a;
                end
                else
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z = z - a;
                end
                x = nx;
                y = ny;
            end
            return z[15:0];
        endfunction

        // advance the search state for one accepted request, queue its goal
        function void note(req_t q);
            res_t e;
            longint gx;
            longint gy;
            longint rr;
            longint hh;
            longint px;
            longint py;
            int s;
            int p;
            int ox;
            int oy;
            bit blk;
            e = '0;
            if (q.func == FUNC_NEXT || q.func == FUNC_RESUME)
            begin
                if (q.func == FUNC_RESUME)
                begin
                    s = 0;
                    while (s < 11 && int'(q.cur_heading) * 12 > (s + 1) * 65536)
                        s++;
                    pt_idx = cw ? SECTOR_CW[s] : SECTOR_CCW[s];
                end
                blk = q.blocked;
                if (blk && q.obstacle_streak >= STREAK_SKIP)
                    pt_idx = pt_idx + 1'b1;
                cw = odd_metres(radius);
                if (pt_idx > INDEX_LAST)
                    pt_idx = '0;
                p = pt_idx;
                if (p == 0)
                begin
                    if (!blk && loops > ROT_GROW_MIN)
                    begin
                        n_grow++;
                        if (int'(radius) + int'(grow_step) > 65535)
                        begin
                            radius = '1;
                            n_sat++;
                        end
                        else
                            radius = radius + grow_step;
                    end
                    pt_idx = odd_metres(radius) ? 4'd1 : 4'd2;
                    loops = '0;
                end
                else if (!blk)
                begin
                    if (cw)
                        pt_idx = (p >= 8) ? 4'd0 : 4'(p + 1);
                    else
                        pt_idx = (p == 9) ? 4'd0 : 4'(p + 1);
                end
                ox = cw ? CW_DX[p] : CCW_DX[p];
                oy = cw ? CW_DY[p] : CCW_DY[p];
                rr = radius;
                hh = radius >> 1;
                gx = ctr_x + (ox == 2 ? rr : ox == -2 ? -rr : ox == 1 ? hh : -hh);
                gy = ctr_y + (oy == 2 ? rr : oy == -2 ? -rr : oy == 1 ? hh : -hh);
                if (loops < ROT_MAX)
                    loops = loops + 1'b1;
                px = $signed(q.cur_x);
                py = $signed(q.cur_y);
                if (gx == px && gy == py)
                    n_zero++;
                if (cw)
                    n_cw++;
                e.goal_x = gx[GOAL_W-1:0];
                e.goal_y = gy[GOAL_W-1:0];
                e.goal_heading = heading_to(gy - py, gx - px);
            end
            else
            begin
                cw = 1'b0;
                loops = '0;
                if (q.func == FUNC_LOST)
                begin
                    pt_idx = q.random_start;
                    radius = RADIUS_RESET;
                end
                else
                    radius = home_radius;
            end
            e.search_position = (pt_idx == 0) ? INDEX_LAST : pt_idx - 1'b1;
            e.radius_now = radius;
            goal_q.push_back(e);
        endfunction

        function void check(logic [71:0] d);
            res_t a;
            res_t e;
            a = d;
            checked++;
            if (goal_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t unexpected result: gx=%0d gy=%0d hd=%0d pos=%0d r=%0d",
                             $time, a.goal_x, a.goal_y, a.goal_heading,
                             a.search_position, a.radius_now);
                return;
            end
            e = goal_q.pop_front();
            if (a.goal_x !== e.goal_x || a.goal_y !== e.goal_y
                || a.goal_heading !== e.goal_heading
                || a.search_position !== e.search_position
                || a.radius_now !== e.radius_now)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%t mismatch on result %0d", $time, checked);
                    $display("  exp gx=%0d gy=%0d hd=%0d pos=%0d r=%0d",
                             e.goal_x, e.goal_y, e.goal_heading, e.search_position,
                             e.radius_now);
                    $display("  got gx=%0d gy=%0d hd=%0d pos=%0d r=%0d",
                             a.goal_x, a.goal_y, a.goal_heading, a.search_position,
                             a.radius_now);
                end
            end
        endfunction

        function int pending();
            return goal_q.size();
        endfunction
    endclass

    waypoint_scoreboard sb;

    octagon_spiral_waypoint_sequencer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic req_t make_req(logic [FUNC_W-1:0] f, logic [POS_W-1:0] x,
                                      logic [POS_W-1:0] y, logic [HEAD_W-1:0] hd,
                                      logic blk, logic [STREAK_W-1:0] streak,
                                      logic [INDEX_W-1:0] rs);
        req_t q;
        q.func = f;
        q.cur_x = x;
        q.cur_y = y;
        q.cur_heading = hd;
        q.blocked = blk;
        q.obstacle_streak = streak;
        q.random_start = rs;
        return q;
    endfunction

    // one of the four offsets the goal can take on this axis
    function automatic longint near_goal(logic [RADIUS_W-1:0] r);
        longint rr;
        rr = r;
        case ($urandom_range(0, 3))
            0:       return rr;
            1:       return -rr;
            2:       return rr >> 1;
            default: return -(rr >> 1);
        endcase
    endfunction

    function automatic req_t random_req();
        req_t q;
        int roll;
        longint tx;
        longint ty;
        roll = $urandom_range(0, 99);
        q.func = roll < 84 ? FUNC_NEXT : roll < 92 ? FUNC_RESUME
               : roll < 96 ? FUNC_LOST : FUNC_RESTORE;
        q.cur_heading = $urandom_range(0, 65535);
        q.blocked = ($urandom_range(0, 9) == 0);
        q.obstacle_streak = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                          : $urandom_range(0, 6);
        q.random_start = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                       : $urandom_range(1, 10);
        roll = $urandom_range(0, 7);
        if (roll < 2)
        begin
            // land on or next to the goal to hit the zero vector now and then
            tx = sb.ctr_x + near_goal(sb.radius);
            ty = sb.ctr_y + near_goal(sb.radius);
            q.cur_x = tx[POS_W-1:0];
            q.cur_y = ty[POS_W-1:0];
        end
        else if (roll == 2)
        begin
            q.cur_x = $urandom_range(0, 1) ? 17'h10000 : 17'h0FFFF;
            q.cur_y = $urandom_range(0, 1) ? 17'h10000 : 17'h0FFFF;
        end
        else
        begin
            q.cur_x = $urandom_range(0, 131071);
            q.cur_y = $urandom_range(0, 131071);
        end
        return q;
    endfunction

    task automatic send_req(req_t q);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= q.func;
        s_tdata <= {1'b0, q.random_start, q.obstacle_streak, q.blocked,
                    q.cur_heading, q.cur_y, q.cur_x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note(q);
        req_count[q.func]++;
    endtask

    // drain the pipe, then write all four registers back to back
    task automatic set_regs(logic [POS_W-1:0] cx, logic [POS_W-1:0] cy,
                            logic [STEP_W-1:0] stp, logic [RADIUS_W-1:0] hr);
        logic [CFG_ADDR_W-1:0] addrs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int k;
        addrs = '{CFG_CENTER_X, CFG_CENTER_Y, CFG_RADIUS_STEP, CFG_START_RADIUS};
        vals = '{cx, cy, CFG_DATA_W'(stp), CFG_DATA_W'(hr)};
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (k = 0; k < 4; k++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= addrs[k];
            cfg_wdata <= vals[k];
            @(posedge clk);
            sb.write_reg(addrs[k], vals[k]);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = idle_cycles();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check(m_tdata);
        end
    end

    initial
    begin
        int ph;
        int n;
        sb = new();
        no_idle = 1'b0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= FUNC_NEXT;
        cfg_we <= 1'b0;
        cfg_addr <= CFG_CENTER_X;
        cfg_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: point 1 ccw at r=500 lands on (500, 250), so start there
        send_req(make_req(FUNC_NEXT, 17'd500, 17'd250, 16'd0, 1'b0, 8'd0, 4'd1));
        send_req(make_req(FUNC_NEXT, 17'h10000, 17'h10000, 16'hFFFF, 1'b0, 8'd0, 4'd1));
        send_req(make_req(FUNC_NEXT, 17'h0FFFF, 17'h0FFFF, 16'd0, 1'b0, 8'd0, 4'd1));
        send_req(make_req(FUNC_NEXT, 17'd0, 17'd0, 16'd0, 1'b1, 8'd255, 4'd1));
        send_req(make_req(FUNC_NEXT, -17'sd300, 17'd900, 16'd0, 1'b1, 8'd3, 4'd1));
        send_req(make_req(FUNC_NEXT, 17'd0, 17'd0, 16'd0, 1'b1, 8'd4, 4'd1));
        // sector bounds are inclusive above
        send_req(make_req(FUNC_RESUME, 17'd10, 17'd20, 16'd0, 1'b0, 8'd0, 4'd1));
        send_req(make_req(FUNC_RESUME, 17'd10, 17'd20, 16'd5461, 1'b0, 8'd0, 4'd1));
        send_req(make_req(FUNC_RESUME, 17'd10, 17'd20, 16'd5462, 1'b0, 8'd0, 4'd1));
        send_req(make_req(FUNC_RESUME, 17'd10, 17'd20, 16'd32768, 1'b0, 8'd0, 4'd1));
        send_req(make_req(FUNC_RESUME, 17'd10, 17'd20, 16'd60075, 1'b0, 8'd0, 4'd1));
        send_req(make_req(FUNC_RESUME, 17'd10, 17'd20, 16'hFFFF, 1'b0, 8'd0, 4'd1));
        // lost reset to index 0 and to an index past the octagon
        send_req(make_req(FUNC_LOST, 17'd0, 17'd0, 16'd0, 1'b0, 8'd0, 4'd0));
        send_req(make_req(FUNC_NEXT, 17'd3, 17'd7, 16'd0, 1'b0, 8'd0, 4'd0));
        send_req(make_req(FUNC_LOST, 17'd0, 17'd0, 16'd0, 1'b0, 8'd0, 4'd15));
        send_req(make_req(FUNC_NEXT, -17'sd3, 17'd7, 16'd0, 1'b0, 8'd0, 4'd15));
        send_req(make_req(FUNC_LOST, 17'd0, 17'd0, 16'd0, 1'b1, 8'd0, 4'd10));
        send_req(make_req(FUNC_NEXT, 17'd0, -17'sd8, 16'd0, 1'b1, 8'd0, 4'd10));
        send_req(make_req(FUNC_RESTORE, 17'd0, 17'd0, 16'd0, 1'b0, 8'd0, 4'd1));
        for (n = 0; n < 5; n++)
            send_req(make_req(FUNC_NEXT, $urandom_range(0, 131071),
                              $urandom_range(0, 131071), 16'd0, 1'b0, 8'd0, 4'd1));

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_regs(17'd0, 17'd0, 10'd1000, 16'd3500);
                1: set_regs(17'h10000, 17'h0FFFF, 10'd0, 16'd0);
                2: set_regs(17'h0FFFF, 17'h10000, 10'd1000, 16'hFFFF);
                3: set_regs($urandom_range(0, 131071), $urandom_range(0, 131071),
                            $urandom_range(0, 1000), $urandom_range(0, 65535));
                4: set_regs($urandom_range(0, 131071), $urandom_range(0, 131071),
                            $urandom_range(500, 1000), $urandom_range(2500, 9999));
                default: set_regs(17'd1234, -17'sd4321, 10'd350, 16'd1250);
            endcase
            for (n = 0; n < 165; n++)
            begin
                no_idle = ((n / 40) % 3 == 2);
                send_req(random_req());
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("requests: next %0d, resume %0d, lost %0d, restore %0d; results %0d",
                 req_count[FUNC_NEXT], req_count[FUNC_RESUME], req_count[FUNC_LOST],
                 req_count[FUNC_RESTORE], sb.checked);
        $display("clockwise legs %0d, radius growths %0d (saturated %0d), on-goal %0d",
                 sb.n_cw, sb.n_grow, sb.n_sat, sb.n_zero);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ospw_pkg.sv
design/ospw_cordic.sv
design/ospw_ctrl.sv
design/octagon_spiral_waypoint_sequencer.sv
bench/tb_octagon_spiral_waypoint_sequencer.sv
